/* sv/nested_scope_self_time_stack_macros.svh */
// assertion macros shared by the profiler stack rtl
`ifndef NESTED_SCOPE_SELF_TIME_STACK_MACROS_SVH
`define NESTED_SCOPE_SELF_TIME_STACK_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define NSST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsst assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define NSST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsst assertion failed");

// condition that must never hold outside reset
`define NSST_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("nsst assertion failed");

`endif

/* sv/nsst_pkg.sv */
// types and constants of the nested scope self time stack
package nsst_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned SID_W   = 16;
  localparam int unsigned DEPTH_W = 6;

  typedef enum logic [0:0] {
    ACT_ENTER = 1'b0,
    ACT_EXIT  = 1'b1
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [TIME_W-1:0]   timestamp_ns;
    logic [SID_W-1:0]    scope_id;
  } in_item_t;

  typedef struct packed {
    logic [SID_W-1:0]    scope_id_out;
    logic [TIME_W-1:0]   inclusive_ns;
    logic [TIME_W-1:0]   self_ns;
    logic [DEPTH_W-1:0]  depth_after;
  } out_item_t;

  // one stack frame: start time and accumulated child time
  typedef struct packed {
    logic [TIME_W-1:0]   start;
    logic [TIME_W-1:0]   child;
  } frame_t;

  // per cell control
  typedef struct packed {
    logic push;
    logic pop;
    logic add;
  } cell_ctrl_t;

endpackage

/* sv/nsst_cell.sv */
// one stack cell: holds a frame, loads a neighbor's frame on push or pop, or adds to its child time
module nsst_cell
  import nsst_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  frame_t             upper_i,
  input  frame_t             lower_i,
  input  logic [TIME_W-1:0]  addend_i,
  output frame_t             frame_o
);

  frame_t frame_q, frame_d;

  always_comb begin
    frame_d = frame_q;
    if (ctrl_i.push) begin
      frame_d = upper_i;
    end else if (ctrl_i.pop) begin
      frame_d = lower_i;
    end else if (ctrl_i.add) begin
      frame_d.child = frame_q.child + addend_i;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_o = frame_q;

endmodule

/* sv/nested_scope_self_time_stack.sv */
// top level of the nested scope self time stack
//
// input channel: drive in_i and raise start; the item is taken at a rising
//   edge where start is high and busy is low
// result channel: done_o is high for exactly one cycle with out_o valid;
//   the receiver cannot stall, so every result must be captured then
// enter pushes {timestamp, 0} onto a shift chain of STACK_DEPTH cells, cell 0
//   being the top; a full stack drops the enter
// exit pops the top cell and forms the inclusive time; the next cycle forms
//   self time and charges inclusive time to the parent frame; exit on an
//   empty stack produces nothing
// enter or exit on an empty stack: busy stays low, no result
// exit that pops: busy is raised by the accepting edge
//   (parent child-time add and self-time compare behind the 64-bit subtract),
//   so the next item can be taken once busy is low again; done_o is
//   registered from busy
// reset: rst_ni low clears depth, busy and the result strobe; frame contents
//   are not cleared, only frames below the depth are ever read
`include "nested_scope_self_time_stack_macros.svh"

module nested_scope_self_time_stack
  import nsst_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_i,
  output logic      done_o,
  output out_item_t out_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  // stack depth and state of an exit in flight
  logic [DW-1:0]     depth_q, depth_d;
  logic              pend_q, pend_d;
  logic [TIME_W-1:0] incl_q;
  logic [TIME_W-1:0] chld_q;
  logic [SID_W-1:0]  sid_q;
  logic [DW-1:0]     dep_q;

  // registered result
  logic              done_q;
  out_item_t         out_q;

  // chain of cells
  frame_t            frame_w [STACK_DEPTH];
  frame_t            push_frame;
  cell_ctrl_t        ctrl_shift;
  logic              add_top;

  logic              accept;
  logic              is_exit;
  logic              full;
  logic              empty;
  logic              do_push;
  logic              do_pop;
  logic [TIME_W-1:0] self_w;

  assign accept  = start && !busy;
  assign is_exit = (in_i.action == ACT_EXIT);
  assign full    = (depth_q == DW'(STACK_DEPTH));
  assign empty   = (depth_q == '0);
  assign do_push = accept && !is_exit && !full;
  assign do_pop  = accept && is_exit && !empty;

  // parent child-time charge happens in the cycle after the pop
  assign add_top = pend_q && (dep_q != '0);

  assign push_frame.start = in_i.timestamp_ns;
  assign push_frame.child = '0;

  assign ctrl_shift.push = do_push;
  assign ctrl_shift.pop  = do_pop;
  assign ctrl_shift.add  = 1'b0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl_w;
    frame_t     upper_w;
    frame_t     lower_w;

    if (i == 0) begin : g_top
      assign upper_w = push_frame;
      always_comb begin
        ctrl_w     = ctrl_shift;
        ctrl_w.add = add_top;
      end
    end else begin : g_mid
      assign upper_w = frame_w[i-1];
      assign ctrl_w  = ctrl_shift;
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign lower_w = '0;
    end else begin : g_nbot
      assign lower_w = frame_w[i+1];
    end

    nsst_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_w),
      .upper_i  (upper_w),
      .lower_i  (lower_w),
      .addend_i (incl_q),
      .frame_o  (frame_w[i])
    );
  end

  // depth and pending control
  always_comb begin
    depth_d = depth_q;
    if (do_push) begin
      depth_d = depth_q + DW'(1);
    end else if (do_pop) begin
      depth_d = depth_q - DW'(1);
    end
  end

  assign pend_d = do_pop;

  // self time, clamped at zero
  assign self_w = (incl_q > chld_q) ? (incl_q - chld_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      depth_q <= depth_d;
      pend_q  <= pend_d;
      done_q  <= pend_q;
    end
  end

  // exit payload, first stage
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      incl_q <= in_i.timestamp_ns - frame_w[0].start;
      chld_q <= frame_w[0].child;
      sid_q  <= in_i.scope_id;
      dep_q  <= depth_q - DW'(1);
    end
  end

  // result register, second stage
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_q.scope_id_out <= sid_q;
      out_q.inclusive_ns <= incl_q;
      out_q.self_ns      <= self_w;
      out_q.depth_after  <= DEPTH_W'(dep_q);
    end
  end

  assign busy   = pend_q;
  assign done_o = done_q;
  assign out_o  = out_q;

  // checks
  `NSST_ASSERT_NEVER(a_depth_bound, clk_i, rst_ni, depth_q > DW'(STACK_DEPTH))
  `NSST_ASSERT_NEXT(a_pop_then_result, clk_i, rst_ni, pend_q, done_o)
  `NSST_ASSERT_NEXT(a_empty_exit_silent, clk_i, rst_ni, accept && is_exit && empty, !pend_q)
  `NSST_ASSERT_IMPL(a_no_double_pend, clk_i, rst_ni, pend_q, !pend_d)
  `NSST_ASSERT_NEXT(a_pop_depth, clk_i, rst_ni, do_pop, depth_q == dep_q)

endmodule
